### rtl/core/fwrap_pkg.sv
// fwrap_pkg: shared types and constants for the queue with indexed removal
// no dependencies; used by fwrap_ctrl, fwrap_cell and the top level
package fwrap_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int FUNC_W    = 2;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int ERR_W     = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_REMOVE  = 2'd2,
    FUNC_STATUS  = 2'd3
  } func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_POS   = 2'd3
  } err_t;

  // per-slot command from the control unit
  typedef struct packed {
    logic load;   // take the appended value
    logic shift;  // take the right neighbor's value
  } cell_ctrl_t;

endpackage

### rtl/core/fwrap_cell.sv
// fwrap_cell: one storage slot of the queue chain
// depends on fwrap_pkg
module fwrap_cell (
  input  logic                              clk,
  input  fwrap_pkg::cell_ctrl_t             ctrl,
  input  logic signed [fwrap_pkg::DATA_W-1:0] in_data,
  input  logic signed [fwrap_pkg::DATA_W-1:0] next_data,
  output logic signed [fwrap_pkg::DATA_W-1:0] slot_q
);

  logic signed [fwrap_pkg::DATA_W-1:0] slot_r;

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot_r <= in_data;
    end else if (ctrl.shift) begin
      slot_r <= next_data;
    end
  end

  assign slot_q = slot_r;

endmodule

### rtl/core/fwrap_ctrl.sv
// fwrap_ctrl: occupancy counter, request checks and per-slot commands
// depends on fwrap_pkg
module fwrap_ctrl #(
  parameter int DEPTH = fwrap_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_fire,
  input  fwrap_pkg::func_t                req_func,
  input  logic [fwrap_pkg::POS_W-1:0]     req_pos,
  output fwrap_pkg::err_t                 req_err,
  output fwrap_pkg::cell_ctrl_t           cell_ctrl [DEPTH],
  output logic [$clog2(DEPTH+1)-1:0]      occ_q
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic [CNT_W-1:0]              occ_r, occ_nxt;
  logic                          is_full, is_empty, pos_bad;
  logic                          do_append, do_remove;
  logic [fwrap_pkg::POS_W-1:0]   rm_idx;
  logic [DEPTH-1:0]              load_vec;

  assign is_full  = (occ_r == CNT_W'(DEPTH));
  assign is_empty = (occ_r == '0);
  assign pos_bad  = (32'(req_pos) >= 32'(occ_r));

  always_comb begin
    req_err   = fwrap_pkg::ERR_OK;
    do_append = 1'b0;
    do_remove = 1'b0;
    rm_idx    = '0;
    case (req_func)
      fwrap_pkg::FUNC_APPEND: begin
        if (is_full) req_err = fwrap_pkg::ERR_FULL;
        else         do_append = 1'b1;
      end
      fwrap_pkg::FUNC_POP: begin
        if (is_empty) req_err = fwrap_pkg::ERR_EMPTY;
        else          do_remove = 1'b1;
      end
      fwrap_pkg::FUNC_REMOVE: begin
        rm_idx = req_pos;
        if (is_empty)     req_err = fwrap_pkg::ERR_EMPTY;
        else if (pos_bad) req_err = fwrap_pkg::ERR_POS;
        else              do_remove = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // slot at the tail loads on append; slots from the removed one on shift left
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      load_vec[i]        = req_fire && do_append && (32'(occ_r) == 32'(i));
      cell_ctrl[i].load  = load_vec[i];
      cell_ctrl[i].shift = req_fire && do_remove && (32'(i) >= 32'(rm_idx));
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (req_fire && do_append) begin
      occ_nxt = occ_r + 1'b1;
    end else if (req_fire && do_remove) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign occ_q = occ_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (req_fire && req_err != fwrap_pkg::ERR_OK) |=> $stable(occ_r))
    else $error("rejected request changed occupancy");

  a_append_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (req_fire && do_append) |=> (occ_r == CNT_W'($past(occ_r) + 1'b1)))
    else $error("append did not grow occupancy");

  a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(load_vec))
    else $error("more than one slot loads");
`endif

endmodule

### rtl/core/fifo_with_remove_at_position.sv
// fifo_with_remove_at_position: top level of the queue with indexed removal
// depends on fwrap_pkg, fwrap_ctrl and fwrap_cell
//
// usage
//   input channel (in_valid/in_ready) carries one request per transaction:
//   in_func selects append at tail, remove head, remove at in_position
//   (position 0 is the head) or status only; in_elem_value is the value
//   appended. output channel (out_valid/out_ready) returns one result per
//   request: error code, head value (zero when empty), head valid and count,
//   all as seen after the request.
//   latency: the result is presented the cycle after the request is taken.
//   throughput: one transaction per cycle while out_ready stays high; every
//   slot of the cell chain loads or shifts in the same cycle, so a removal
//   at any position is taken at the same rate as an append.
//   stall: while a result waits with out_ready low, in_ready is low and the
//   queue state is frozen; it rises in the same cycle the result is taken.
//   rejected requests (append when full, removal when empty, position not
//   below the count) report an error and leave the queue unchanged.
//   reset: synchronous, active low; the queue comes up empty with no result
//   pending; slot contents are not cleared and are never shown until written.
module fifo_with_remove_at_position #(
  parameter int DEPTH = fwrap_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [fwrap_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [fwrap_pkg::DATA_W-1:0]  in_elem_value,
  input  logic [fwrap_pkg::POS_W-1:0]          in_position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [fwrap_pkg::ERR_W-1:0]          out_error_code,
  output logic signed [fwrap_pkg::DATA_W-1:0]  out_head_value,
  output logic                                 out_head_valid,
  output logic [fwrap_pkg::COUNT_W-1:0]        out_count
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic                                 in_fire;
  logic                                 out_valid_r, out_valid_nxt;
  fwrap_pkg::err_t                      out_err_r;
  fwrap_pkg::err_t                      req_err;
  fwrap_pkg::cell_ctrl_t                cell_ctrl [DEPTH];
  logic [CNT_W-1:0]                     occ;
  logic signed [fwrap_pkg::DATA_W-1:0]  slot_data [DEPTH];

  // a new transaction is taken whenever the result register is free or drains
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  fwrap_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_fire (in_fire),
    .req_func (fwrap_pkg::func_t'(in_func)),
    .req_pos  (in_position),
    .req_err  (req_err),
    .cell_ctrl(cell_ctrl),
    .occ_q    (occ)
  );

  // chain of slots, slot 0 is the head; each takes its right neighbor on removal
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [fwrap_pkg::DATA_W-1:0] nb_data;
    if (i == DEPTH - 1) begin : g_last
      assign nb_data = slot_data[i];
    end else begin : g_mid
      assign nb_data = slot_data[i+1];
    end
    fwrap_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[i]),
      .in_data  (in_elem_value),
      .next_data(nb_data),
      .slot_q   (slot_data[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // error code is payload, captured with the request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_err_r <= req_err;
    end
  end

  // queue state cannot move while a result is pending, so head and count
  // come straight from the state registers
  assign out_valid      = out_valid_r;
  assign out_error_code = out_err_r;
  assign out_head_valid = (occ != '0);
  assign out_head_value = out_head_valid ? slot_data[0] : '0;
  assign out_count      = fwrap_pkg::COUNT_W'(32'(occ));

endmodule
